@@ hdl/hrclt_pkg.sv @@
// Shared types and constants for the heap region cell lookup table.
package hrclt_pkg;

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_LOOKUP = 3'd2;
	localparam logic [2:0] REQ_ALLOC  = 3'd3;
	localparam logic [2:0] REQ_FREE   = 3'd4;
	localparam logic [2:0] REQ_SETLV  = 3'd5;
	localparam logic [2:0] REQ_TOTALS = 3'd6;
	localparam logic [2:0] REQ_UNDEF  = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] KIND_ARENA = 2'd0;
	localparam logic [1:0] KIND_LARGE = 2'd1;
	localparam logic [1:0] KIND_CODE  = 2'd2;
	localparam logic [1:0] KIND_UNDEF = 2'd3;

	localparam logic [3:0] FLAG_SWEEP   = 4'h1;
	localparam logic [3:0] FLAG_COMPACT = 4'h2;
	localparam logic [3:0] FLAG_EXEC    = 4'h4;
	localparam logic [3:0] FLAG_DECOMMIT = 4'h8;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [47:0] addr;
		logic [31:0] region_size;
		logic [15:0] size_class;
		logic [31:0] zone;
		logic [1:0]  region_kind;
		logic [31:0] live_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  entry_pos;
		logic        index_ok;
		logic [31:0] cell_idx;
		logic [3:0]  region_flags;
		logic [31:0] zone_out;
		logic [31:0] live_count;
		logic [31:0] cell_total;
		logic [4:0]  entry_count;
		logic [35:0] total_bytes;
		logic [51:0] live_bytes;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, clear scan pointer
		logic scan_step; // compare entry at pointer, advance on a miss
		logic div_start;
		logic div_step;
		logic do_add;
		logic do_update;  // alloc/free/set live on match
		logic shift_step; // move next entry down one
		logic shift_done; // drop last entry
		logic acc_step;   // totals accumulation of current entry
		logic mul_step;   // fold registered product into live sum
		logic finish;     // emit result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;   // pointer reached used count
		logic hit;        // match at pointer
		logic div_done;
		logic full;
		logic shift_end;
		logic [2:0] req_type;
	} sts_t;

endpackage

@@ hdl/hrclt_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle while step is high.
module hrclt_div #(
	parameter int NB = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          step,
	input  logic [NB-1:0] dividend,
	input  logic [15:0]   divisor,
	output logic [NB-1:0] quot,
	output logic [15:0]   rem,
	output logic          done
);
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] q_q;
	logic [16:0]   r_q;
	logic [15:0]   d_q;
	logic [CW-1:0] cnt_q;
	logic [16:0]   trial;

	assign trial = {r_q[15:0], q_q[NB-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NB);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (step && cnt_q != '0) begin
			if (!trial[16]) begin
				r_q <= trial;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= {r_q[15:0], q_q[NB-1]};
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign rem  = r_q[15:0];
	assign done = (cnt_q == '0);
endmodule

@@ hdl/hrclt_ctrl.sv @@
// Sequencer for the region table requests.
module hrclt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output hrclt_pkg::cmd_t cmd,
	input  hrclt_pkg::sts_t sts
);
	import hrclt_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_ADD   = 4'd4;
	localparam logic [3:0] S_SHIFT = 4'd5;
	localparam logic [3:0] S_ACC   = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;
	localparam logic [3:0] S_DIVW  = 4'd9;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.req_type == REQ_ADD) begin
					if (sts.full) begin
						state_d = S_DONE;
					end else begin
						cmd.div_start = 1'b1;
						state_d = S_DIV;
					end
				end else if (sts.req_type == REQ_TOTALS) begin
					state_d = S_ACC;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_DONE;
				end else if (sts.hit) begin
					cmd.scan_step = 1'b1;
					if (sts.req_type == REQ_REMOVE) begin
						state_d = S_SHIFT;
					end else if (sts.req_type == REQ_LOOKUP) begin
						cmd.div_start = 1'b1;
						state_d = S_DIVW;
					end else begin
						cmd.do_update = 1'b1;
						state_d = S_DONE;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_ADD;
				else cmd.div_step = 1'b1;
			end
			S_DIVW: begin
				if (sts.div_done) state_d = S_DONE;
				else cmd.div_step = 1'b1;
			end
			S_ADD: begin
				cmd.do_add = 1'b1;
				state_d = S_DONE;
			end
			S_SHIFT: begin
				if (sts.shift_end) begin
					cmd.shift_done = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_ACC: begin
				if (sts.scan_end) begin
					state_d = S_MUL;
				end else begin
					cmd.acc_step = 1'b1;
				end
			end
			S_MUL: begin
				// fold last registered product
				cmd.mul_step = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ hdl/hrclt_dp.sv @@
// Region table storage, scan pointer and result assembly.
module hrclt_dp #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  hrclt_pkg::req_t req,
	input  hrclt_pkg::cmd_t cmd,
	output hrclt_pkg::sts_t sts,
	output logic done,
	output hrclt_pkg::rsp_t rsp
);
	import hrclt_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [ADDR_BITS-1:0] base_m [ENTRIES];
	logic [31:0] size_m  [ENTRIES];
	logic [15:0] csz_m   [ENTRIES];
	logic [31:0] zone_m  [ENTRIES];
	logic [3:0]  flag_m  [ENTRIES];
	logic [31:0] cells_m [ENTRIES];
	logic [31:0] live_m  [ENTRIES];

	req_t        req_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] hit_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [35:0] tb_q;
	logic [51:0] lb_q;
	logic [47:0] prod_q;
	rsp_t        rsp_q;
	logic        done_q;
	logic        full_q;
	logic        found_q;

	logic [ADDR_BITS-1:0] a;
	logic [IW-1:0] pi;
	logic [IW-1:0] pn;
	logic hit;
	logic scan_req;
	logic [ADDR_BITS-1:0] off;
	logic [ADDR_BITS-1:0] div_n;
	logic [15:0] div_d;
	logic [ADDR_BITS-1:0] quot;
	logic [15:0] rem;
	logic div_done;
	logic [3:0] nflags;
	logic [31:0] nlive;

	assign a  = ADDR_BITS'(req_q.addr);
	assign pi = ptr_q[IW-1:0];
	assign pn = IW'(ptr_q + 1'b1);
	assign off = a - base_m[pi];
	// requests that report a matched entry
	assign scan_req = req_q.req_type inside {REQ_REMOVE, REQ_LOOKUP, REQ_ALLOC,
		REQ_FREE, REQ_SETLV};

	always_comb begin
		if (req_q.req_type == REQ_REMOVE) hit = (base_m[pi] == a);
		else hit = (a >= base_m[pi]) && (off < ADDR_BITS'(size_m[pi]));
	end

	assign div_n = cmd.div_start && (req_q.req_type == REQ_ADD)
		? ADDR_BITS'(req_q.region_size) : (cmd.div_start ? off : off_q);
	assign div_d = (req_q.req_type == REQ_ADD) ? req_q.size_class : csz_m[pi];

	hrclt_div #(.NB(ADDR_BITS)) u_div (
		.clk, .arst_n,
		.start(cmd.div_start), .step(cmd.div_step),
		.dividend(div_n), .divisor(div_d),
		.quot, .rem, .done(div_done)
	);

	assign sts.scan_end  = (ptr_q >= used_q);
	assign sts.hit       = hit;
	assign sts.div_done  = div_done;
	assign sts.full      = (used_q >= CW'(ENTRIES));
	assign sts.shift_end = (CW'(ptr_q + 1'b1) >= used_q);
	assign sts.req_type  = req_q.req_type;

	always_comb begin
		nflags = FLAG_SWEEP;
		if (req_q.region_kind == KIND_ARENA) nflags = nflags | FLAG_COMPACT;
		if (req_q.region_kind == KIND_CODE)  nflags = nflags | FLAG_EXEC;
	end

	always_comb begin
		nlive = live_m[pi];
		case (req_q.req_type)
			REQ_ALLOC: if (live_m[pi] != '1) nlive = live_m[pi] + 1'b1;
			REQ_FREE:  if (live_m[pi] != '0) nlive = live_m[pi] - 1'b1;
			REQ_SETLV: nlive = req_q.live_value;
			default:   nlive = live_m[pi];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ptr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) ptr_q <= '0;
			else if (cmd.scan_step && !hit) ptr_q <= ptr_q + 1'b1;
			else if (cmd.shift_step) ptr_q <= ptr_q + 1'b1;
			else if (cmd.acc_step) ptr_q <= ptr_q + 1'b1;
			if (cmd.do_add) used_q <= used_q + 1'b1;
			if (cmd.shift_done) used_q <= used_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req;
			rsp_q   <= '0;
			tb_q    <= '0;
			lb_q    <= '0;
			prod_q  <= '0;
			full_q  <= (used_q >= CW'(ENTRIES));
			found_q <= 1'b0;
		end
		if (cmd.div_start) off_q <= off;
		if (cmd.scan_step && hit && scan_req) begin
			hit_q   <= pi;
			found_q <= 1'b1;
			rsp_q.entry_pos    <= 4'(pi);
			rsp_q.region_flags <= flag_m[pi];
			rsp_q.zone_out     <= zone_m[pi];
			rsp_q.cell_total   <= cells_m[pi];
			rsp_q.live_count   <= (req_q.req_type == REQ_REMOVE ||
				req_q.req_type == REQ_LOOKUP) ? live_m[pi] : nlive;
			if (req_q.req_type == REQ_ALLOC || req_q.req_type == REQ_FREE ||
				req_q.req_type == REQ_SETLV) live_m[pi] <= nlive;
		end
		if (cmd.do_add) begin
			base_m[used_q[IW-1:0]]  <= a;
			size_m[used_q[IW-1:0]]  <= req_q.region_size;
			csz_m[used_q[IW-1:0]]   <= req_q.size_class;
			zone_m[used_q[IW-1:0]]  <= req_q.zone;
			flag_m[used_q[IW-1:0]]  <= nflags;
			cells_m[used_q[IW-1:0]] <= (req_q.size_class == '0) ? 32'd1 : quot[31:0];
			live_m[used_q[IW-1:0]]  <= '0;
			rsp_q.entry_pos    <= 4'(used_q);
			rsp_q.region_flags <= nflags;
			rsp_q.zone_out     <= req_q.zone;
			rsp_q.live_count   <= '0;
			rsp_q.cell_total   <= (req_q.size_class == '0) ? 32'd1 : quot[31:0];
		end
		if (cmd.shift_step) begin
			base_m[pi]  <= base_m[pn];
			size_m[pi]  <= size_m[pn];
			csz_m[pi]   <= csz_m[pn];
			zone_m[pi]  <= zone_m[pn];
			flag_m[pi]  <= flag_m[pn];
			cells_m[pi] <= cells_m[pn];
			live_m[pi]  <= live_m[pn];
		end
		if (cmd.acc_step) begin
			tb_q   <= tb_q + 36'(size_m[pi]);
			prod_q <= live_m[pi] * csz_m[pi];
			lb_q   <= lb_q + 52'(prod_q);
		end
		if (cmd.mul_step) lb_q <= lb_q + 52'(prod_q);
		if (cmd.finish) begin
			if (req_q.req_type == REQ_ADD && full_q) rsp_q.status <= ST_FULL;
			else if (req_q.req_type == REQ_TOTALS) begin
				rsp_q.entry_count <= 5'(used_q);
				rsp_q.total_bytes <= tb_q;
				rsp_q.live_bytes  <= lb_q;
			end else if (req_q.req_type != REQ_ADD && !found_q) begin
				// nothing was captured, so the rest of the beat is still zero
				rsp_q.status <= ST_NOMATCH;
			end else if (req_q.req_type == REQ_LOOKUP) begin
				if (csz_m[hit_q] != '0 && rem == '0 &&
					quot < ADDR_BITS'(cells_m[hit_q])) begin
					rsp_q.index_ok <= 1'b1;
					rsp_q.cell_idx <= quot[31:0];
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

@@ hdl/heap_region_cell_lookup_table.sv @@
// Top level of the heap region cell lookup table.
// Sequence per request: add runs the cell count division, lookup scans the table then does
// a bit-per-cycle divide, remove scans then shifts the later entries down, totals accumulates
// every entry, alloc/free/set live scan for the match, and add on a full table skips the division.
// One request at a time; results appear for one cycle on done; the receiver cannot stall.
// Reset clears the entry count and the sequencer; table contents are left as is.
module heap_region_cell_lookup_table #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hrclt_pkg::req_t req,
	output logic done,
	output hrclt_pkg::rsp_t rsp
);
	import hrclt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hrclt_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .cmd, .sts);

	hrclt_dp #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk, .arst_n, .req, .cmd, .sts, .done, .rsp
	);
endmodule

@@ hdl/hrclt_checker.sv @@
// Port-level checks for the heap region table, bound to the top level.
module hrclt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input hrclt_pkg::rsp_t rsp
);
	import hrclt_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_NOMATCH |-> rsp.zone_out == '0 && !rsp.index_ok)
		else $error("no-match result carries data");
endmodule

bind heap_region_cell_lookup_table hrclt_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .rsp
);

@@ sim/testbench.sv @@
// Testbench for the heap region cell lookup table: queued requests, region table predictor, checker.
`timescale 1ns / 100ps

module testbench;
	import hrclt_pkg::*;

	localparam int NREG = 16;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	heap_region_cell_lookup_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	// predictor copy of the region table
	logic [47:0] rg_base [NREG];
	logic [31:0] rg_size [NREG];
	logic [15:0] rg_csize [NREG];
	logic [31:0] rg_zone [NREG];
	logic [3:0]  rg_flags [NREG];
	logic [31:0] rg_cells [NREG];
	logic [31:0] rg_live [NREG];
	int          rg_used;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int   errors;
	int   watchdog;
	int   gap_left;
	bit   calm;       // no idling in the last part of the run
	bit   hold_drain; // sender waits until all results arrived
	int   n_lookup_hits;
	int   n_full;

	function automatic rsp_t show_region(int i);
		rsp_t r;
		r = '0;
		r.entry_pos = i[3:0];
		r.region_flags = rg_flags[i];
		r.zone_out = rg_zone[i];
		r.live_count = rg_live[i];
		r.cell_total = rg_cells[i];
		return r;
	endfunction

	function automatic rsp_t region_table_step(req_t q);
		rsp_t r;
		int m;
		logic [63:0] tb, lb, off;
		r = '0;
		m = -1;
		case (q.req_type)
			REQ_ADD: begin
				if (rg_used >= NREG) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					m = rg_used;
					rg_base[m] = q.addr;
					rg_size[m] = q.region_size;
					rg_csize[m] = q.size_class;
					rg_zone[m] = q.zone;
					rg_flags[m] = FLAG_SWEEP;
					if (q.region_kind == KIND_ARENA) rg_flags[m] |= FLAG_COMPACT;
					if (q.region_kind == KIND_CODE) rg_flags[m] |= FLAG_EXEC;
					rg_cells[m] = (q.size_class != 0) ? q.region_size / q.size_class : 32'd1;
					rg_live[m] = 0;
					rg_used++;
					r = show_region(m);
				end
			end
			REQ_REMOVE: begin
				for (int i = 0; i < rg_used; i++)
					if (m < 0 && rg_base[i] == q.addr) m = i;
				if (m < 0) r.status = ST_NOMATCH;
				else begin
					r = show_region(m);
					for (int i = m; i + 1 < rg_used; i++) begin
						rg_base[i] = rg_base[i+1];
						rg_size[i] = rg_size[i+1];
						rg_csize[i] = rg_csize[i+1];
						rg_zone[i] = rg_zone[i+1];
						rg_flags[i] = rg_flags[i+1];
						rg_cells[i] = rg_cells[i+1];
						rg_live[i] = rg_live[i+1];
					end
					rg_used--;
				end
			end
			REQ_TOTALS: begin
				tb = 0;
				lb = 0;
				for (int i = 0; i < rg_used; i++) begin
					tb += rg_size[i];
					lb += 64'(rg_live[i]) * 64'(rg_csize[i]);
				end
				r.entry_count = rg_used[4:0];
				r.total_bytes = tb[35:0];
				r.live_bytes = lb[51:0];
			end
			REQ_LOOKUP, REQ_ALLOC, REQ_FREE, REQ_SETLV: begin
				for (int i = 0; i < rg_used; i++)
					if (m < 0 && q.addr >= rg_base[i]
						&& 64'(q.addr - rg_base[i]) < 64'(rg_size[i])) m = i;
				if (m < 0) r.status = ST_NOMATCH;
				else begin
					if (q.req_type == REQ_ALLOC && rg_live[m] != 32'hFFFF_FFFF) rg_live[m]++;
					if (q.req_type == REQ_FREE && rg_live[m] != 0) rg_live[m]--;
					if (q.req_type == REQ_SETLV) rg_live[m] = q.live_value;
					r = show_region(m);
					if (q.req_type == REQ_LOOKUP && rg_csize[m] != 0) begin
						off = 64'(q.addr - rg_base[m]);
						if (off % rg_csize[m] == 0 && off / rg_csize[m] < rg_cells[m]) begin
							r.index_ok = 1'b1;
							r.cell_idx = 32'(off / rg_csize[m]);
							n_lookup_hits++;
						end
					end
				end
			end
			default: r.status = ST_NOMATCH;
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else if (start && !busy) begin
			start <= 1'b0;
			expected_rsps.insert(expected_rsps.size(), region_table_step(req));
			gap_left <= (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		end else if (!start) begin
			if (gap_left > 0) gap_left <= gap_left - 1;
			else if (hold_drain && expected_rsps.size() != 0) begin
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, rsp);
				errors++;
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp !== e) begin
					$display("%0t: mismatch expected %h actual %h", $time, e, rsp);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WATCH_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", watchdog);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t blank_req(logic [2:0] t, logic [47:0] a);
		req_t q;
		q = '0;
		q.req_type = t;
		q.addr = a;
		return q;
	endfunction

	// append one beat to the send queue
	task automatic enqueue_req(req_t q);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	task automatic queue_add(logic [47:0] b, logic [31:0] s, logic [15:0] c,
		logic [31:0] z, logic [1:0] k);
		req_t q;
		q = blank_req(REQ_ADD, b);
		q.region_size = s;
		q.size_class = c;
		q.zone = z;
		q.region_kind = k;
		enqueue_req(q);
	endtask

	// pool of bases in use so that random requests hit often
	logic [47:0] base_pool [$];
	logic [31:0] size_pool [$];
	logic [15:0] cls_pool [$];

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	task automatic queue_random();
		req_t q;
		int k;
		logic [47:0] b;
		logic [15:0] c;
		q = '0;
		q.req_type = 3'($urandom_range(0, 7));
		q.addr = rand48();
		q.region_size = $urandom();
		q.size_class = 16'($urandom());
		q.zone = $urandom();
		q.region_kind = 2'($urandom_range(0, 3));
		q.live_value = $urandom();
		if (q.req_type == REQ_ADD) begin
			if ($urandom_range(0, 3) != 0) q.size_class = 16'($urandom_range(0, 64));
			if ($urandom_range(0, 3) != 0) q.region_size = $urandom_range(0, 4096);
			if ($urandom_range(0, 3) != 0) q.addr = {32'h0, 4'($urandom_range(0, 3)), 12'h0};
			base_pool.insert(base_pool.size(), q.addr);
			size_pool.insert(size_pool.size(), q.region_size);
			cls_pool.insert(cls_pool.size(), q.size_class);
		end else if (base_pool.size() != 0 && $urandom_range(0, 7) != 0) begin
			k = $urandom_range(0, base_pool.size() - 1);
			b = base_pool[k];
			c = cls_pool[k];
			if (q.req_type == REQ_REMOVE) q.addr = b;
			else if (c != 0 && $urandom_range(0, 1) == 1)
				q.addr = b + 48'(c) * 48'($urandom_range(0, 70));
			else q.addr = b + 48'($urandom_range(0, size_pool[k] + 2));
			if (q.req_type == REQ_SETLV && $urandom_range(0, 1) == 1)
				q.live_value = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFE : 32'd0;
		end
		if (q.req_type == REQ_REMOVE && base_pool.size() > 40) begin
			void'(base_pool.pop_front());
			void'(size_pool.pop_front());
			void'(cls_pool.pop_front());
		end
		enqueue_req(q);
	endtask

	initial begin
		req_t q;
		errors = 0;
		n_lookup_hits = 0;
		n_full = 0;
		rg_used = 0;
		calm = 0;
		hold_drain = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every kind, extremes, saturation, full table, no match
		queue_add(48'h0000_1000, 32'd256, 16'd16, 32'hFFFF_FFFF, KIND_ARENA);
		queue_add(48'hFFFF_FFFF_F000, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, KIND_LARGE);
		queue_add(48'h0000_2000, 32'd100, 16'd0, 32'd7, KIND_CODE);
		queue_add(48'h0000_3000, 32'd0, 16'd8, 32'd9, KIND_UNDEF);
		enqueue_req(blank_req(REQ_LOOKUP, 48'h0000_1020));
		enqueue_req(blank_req(REQ_LOOKUP, 48'h0000_1021));
		enqueue_req(blank_req(REQ_LOOKUP, 48'h0000_2000));
		enqueue_req(blank_req(REQ_LOOKUP, 48'h0000_3000));
		enqueue_req(blank_req(REQ_FREE, 48'h0000_1000));
		enqueue_req(blank_req(REQ_ALLOC, 48'h0000_10FF));
		q = blank_req(REQ_SETLV, 48'h0000_1000);
		q.live_value = 32'hFFFF_FFFF;
		enqueue_req(q);
		enqueue_req(blank_req(REQ_ALLOC, 48'h0000_1000));
		enqueue_req(blank_req(REQ_TOTALS, 48'h0));
		enqueue_req(blank_req(REQ_UNDEF, 48'h0000_1000));
		enqueue_req(blank_req(REQ_REMOVE, 48'h0000_5555));
		enqueue_req(blank_req(REQ_REMOVE, 48'h0000_1000));
		for (int i = 0; i < 13; i++)
			queue_add(48'h0001_0000 + 48'(i) * 48'h100, 32'd64, 16'd4, 32'(i), 2'(i % 3));
		enqueue_req(blank_req(REQ_TOTALS, 48'h0));
		enqueue_req(blank_req(REQ_ALLOC, 48'hFFFF_FFFF_FFFF));
		enqueue_req(blank_req(REQ_REMOVE, 48'hFFFF_FFFF_F000));

		// drain fully before the random part
		hold_drain = 1;
		wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !start);
		hold_drain = 0;

		for (int i = 0; i < 1730; i++) queue_random();
		wait (pending_reqs.size() < 250);
		calm = 1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_rsps.size() == 0);
		repeat (120) @(posedge clk);
		$display("Covered about 1750 requests of every type, with full and empty table cases;");
		$display("%0d aligned lookups hit a cell, %0d adds found the table full.",
			n_lookup_hits, n_full);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
